### hdl/ple_pkg.sv
package ple_pkg;

   localparam int unsigned DEFAULT_DEPTH = 16;

   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned POS_W    = 5;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic                     load;
      logic                     ins;
      logic                     del;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

### hdl/ple_req_if.sv
interface ple_req_if;
   import ple_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink (input valid, input func, input position, input value, output ready);
endinterface

### hdl/ple_rsp_if.sv
interface ple_rsp_if;
   import ple_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] read_value;
   logic [COUNT_W-1:0]       found_at;
   logic [COUNT_W-1:0]       count;
   logic                     is_empty;

   modport source (output valid, output status, output read_value, output found_at,
                   output count, output is_empty, input ready);
   modport sink (input valid, input status, input read_value, input found_at,
                 input count, input is_empty, output ready);
endinterface

### hdl/ple_cell.sv
module ple_cell #(
   parameter int unsigned DEPTH = ple_pkg::DEFAULT_DEPTH,
   parameter int unsigned INDEX = 0
) (
   input  logic                             clock,
   input  ple_pkg::cell_cmd_type            cmd,
   input  logic signed [ple_pkg::DATA_W-1:0] left_entry,
   input  logic signed [ple_pkg::DATA_W-1:0] right_entry,
   output logic signed [ple_pkg::DATA_W-1:0] entry,
   output logic                             hit,
   output logic                             sel
);
   import ple_pkg::*;

   localparam int unsigned SW = $clog2(DEPTH + 1);
   localparam int unsigned CW = (SW > POS_W) ? SW : POS_W;
   localparam logic [CW-1:0] SLOT = CW'(INDEX + 1);

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic                     hit_ff, hit_in;
   logic                     sel_ff, sel_in;
   logic [CW-1:0]            pos_x;

   assign pos_x = CW'(cmd.position);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (SLOT == pos_x) begin
            entry_in = cmd.value;
         end else if (SLOT > pos_x) begin
            entry_in = left_entry;
         end
      end else if (cmd.del) begin
         if (SLOT >= pos_x) begin
            entry_in = right_entry;
         end
      end
   end

   // compare against the list as it stands before the word
   always_comb begin
      hit_in = hit_ff;
      sel_in = sel_ff;
      if (cmd.load) begin
         hit_in = (entry_ff == cmd.value);
         sel_in = (SLOT == pos_x);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
      sel_ff   <= sel_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;
   assign sel   = sel_ff;

endmodule

### hdl/positional_list_engine_core.sv
// positional list engine: ordered list of up to DEPTH signed 32-bit values
// req_bus (valid/ready) takes one word: func, position, value
//   insert at position, delete at position, read at position, find value, clear
// rsp_bus (valid/ready) returns one word per request: status, read_value,
//   found_at, count, is_empty
// when a request is accepted, the row of cells shifts or compares
//   all entries in parallel in that cycle
// the next cycle reduces the cell flags (first match, read select) into the
//   output register and raises rsp valid
// one request in flight at a time: a new word is taken only after the last is evaluated
// req ready drops while a request is being evaluated, and also while the
//   output register holds a word that rsp ready has not taken
// a stalled response holds steady until taken
// reset (synchronous) empties the list and drops rsp valid; entry storage
//   is not cleared, entries past the count are never read
module positional_list_engine_core #(
   parameter int unsigned DEPTH = ple_pkg::DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_bus,
   ple_rsp_if.source rsp_bus
);
   import ple_pkg::*;

   localparam int unsigned UW = $clog2(DEPTH + 1);
   localparam int unsigned CW = ((UW > POS_W) ? UW : POS_W) + 1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                read_ok;
      logic                find;
      logic [COUNT_W-1:0]  count;
      logic                empty;
   } pend_type;

   state_type state_ff, state_in;
   logic [UW-1:0] used_ff, used_in;
   pend_type      pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      status_ff;
   logic signed [DATA_W-1:0] read_value_ff, read_value_in;
   logic [COUNT_W-1:0]       found_at_ff, found_at_in;
   logic [COUNT_W-1:0]       count_ff;
   logic                     is_empty_ff;

   logic          req_fire;
   logic [CW-1:0] pos_x, used_x;
   logic          ins_bad, pos_bad, full;
   logic [STATUS_W-1:0] status_calc;
   cell_cmd_type  cmd;

   logic signed [DATA_W-1:0] entry_q [DEPTH];
   logic [DEPTH-1:0]         hit_q;
   logic [DEPTH-1:0]         sel_q;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign pos_x   = CW'(req_bus.position);
   assign used_x  = CW'(used_ff);
   assign ins_bad = (pos_x == '0) || (pos_x > used_x + CW'(1));
   assign pos_bad = (pos_x == '0) || (pos_x > used_x);
   assign full    = (used_ff == UW'(DEPTH));

   always_comb begin
      status_calc = STATUS_OK;
      used_in     = used_ff;
      case (req_bus.func)
         FUNC_INSERT: begin
            if (ins_bad) begin
               status_calc = STATUS_RANGE;
            end else if (full) begin
               status_calc = STATUS_FULL;
            end else if (req_fire) begin
               used_in = used_ff + UW'(1);
            end
         end
         FUNC_DELETE: begin
            if (pos_bad) begin
               status_calc = STATUS_RANGE;
            end else if (req_fire) begin
               used_in = used_ff - UW'(1);
            end
         end
         FUNC_READ: begin
            if (pos_bad) begin
               status_calc = STATUS_RANGE;
            end
         end
         FUNC_CLEAR: begin
            if (req_fire) begin
               used_in = '0;
            end
         end
         default: begin
            status_calc = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      cmd.load     = req_fire;
      cmd.ins      = req_fire && (req_bus.func == FUNC_INSERT) && (status_calc == STATUS_OK);
      cmd.del      = req_fire && (req_bus.func == FUNC_DELETE) && (status_calc == STATUS_OK);
      cmd.position = req_bus.position;
      cmd.value    = req_bus.value;
   end

   always_comb begin
      pend_in = pend_ff;
      if (req_fire) begin
         pend_in.status  = status_calc;
         pend_in.read_ok = (req_bus.func == FUNC_READ) && (status_calc == STATUS_OK);
         pend_in.find    = (req_bus.func == FUNC_FIND);
         pend_in.count   = COUNT_W'(used_in);
         pend_in.empty   = (used_in == '0);
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [DATA_W-1:0] left_entry, right_entry;
         if (g == 0) begin : g_first
            assign left_entry = entry_q[g];
         end else begin : g_mid_l
            assign left_entry = entry_q[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_entry = entry_q[g];
         end else begin : g_mid_r
            assign right_entry = entry_q[g+1];
         end
         ple_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry_q[g]),
            .hit         (hit_q[g]),
            .sel         (sel_q[g])
         );
      end
   endgenerate

   // first live match, and the selected entry
   always_comb begin
      found_at_in   = '0;
      read_value_in = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (pend_ff.find && hit_q[i] && (UW'(i) < used_ff)) begin
            found_at_in = COUNT_W'(i + 1);
         end
         if (pend_ff.read_ok) begin
            read_value_in = read_value_in | (entry_q[i] & {DATA_W{sel_q[i]}});
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (state_ff == ST_EVAL) begin
         status_ff     <= pend_ff.status;
         read_value_ff <= read_value_in;
         found_at_ff   <= found_at_in;
         count_ff      <= pend_ff.count;
         is_empty_ff   <= pend_ff.empty;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.read_value = read_value_ff;
   assign rsp_bus.found_at   = found_at_ff;
   assign rsp_bus.count      = count_ff;
   assign rsp_bus.is_empty   = is_empty_ff;

`ifndef SYNTHESIS
   a_fire_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EVAL))
      else $error("accepted word did not enter evaluation");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(DEPTH))
      else $error("entry count beyond depth");

   a_rsp_after_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EVAL))
      else $error("response raised without evaluation");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> !req_fire)
      else $error("word accepted during evaluation");
`endif

endmodule

### tb/sv/positional_list_engine_core_checker.sv
`timescale 1ns / 1ps

module positional_list_engine_core_checker #(
   parameter int unsigned DEPTH = ple_pkg::DEFAULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   ple_req_if          req_bus,
   ple_rsp_if          rsp_bus,
   output int unsigned fail_count,
   output int unsigned pending_count,
   output int unsigned list_length,
   output int unsigned checked_count,
   output int unsigned range_count,
   output int unsigned full_count,
   output int unsigned hit_count
);
   import ple_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] read_value;
      logic [COUNT_W-1:0]       found_at;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
   } list_result_type;

   logic signed [DATA_W-1:0] list_mem [DEPTH];
   int unsigned              held;
   list_result_type          expected_q[$];
   int unsigned              errors;
   int unsigned              checked;
   int unsigned              range_rejects;
   int unsigned              full_rejects;
   int unsigned              find_hits;

   assign fail_count    = errors;
   assign checked_count = checked;
   assign range_count   = range_rejects;
   assign full_count    = full_rejects;
   assign hit_count     = find_hits;

   // shadow of the list; updates the stored entries as the block should
   function automatic list_result_type apply_request(input logic [FUNC_W-1:0] f,
                                                     input logic [POS_W-1:0] p,
                                                     input logic signed [DATA_W-1:0] v);
      list_result_type r;
      int unsigned     i;
      r = '0;
      case (f)
         FUNC_INSERT: begin
            if (p == 0 || p > held + 1) begin
               r.status = STATUS_RANGE;
            end else if (held >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               for (i = held; i > p - 1; i--) list_mem[i] = list_mem[i-1];
               list_mem[p-1] = v;
               held++;
            end
         end
         FUNC_DELETE: begin
            if (p == 0 || p > held) begin
               r.status = STATUS_RANGE;
            end else begin
               for (i = p - 1; i + 1 < held; i++) list_mem[i] = list_mem[i+1];
               held--;
            end
         end
         FUNC_READ: begin
            if (p == 0 || p > held) begin
               r.status = STATUS_RANGE;
            end else begin
               r.read_value = list_mem[p-1];
            end
         end
         FUNC_FIND: begin
            for (i = 0; i < held; i++) begin
               if (list_mem[i] == v) begin
                  r.found_at = COUNT_W'(i + 1);
                  break;
               end
            end
         end
         FUNC_CLEAR: begin
            held = 0;
         end
         default: begin
         end
      endcase
      r.count    = COUNT_W'(held);
      r.is_empty = (held == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: response %0d %s mismatch: got %0h, expected %0h",
               $realtime, checked, field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         held = 0;
         expected_q.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected word", 32'(rsp_bus.status), '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
               if (rsp_bus.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_bus.read_value, want.read_value);
               if (rsp_bus.found_at !== want.found_at)
                  report_mismatch("found_at", 32'(rsp_bus.found_at), 32'(want.found_at));
               if (rsp_bus.count !== want.count)
                  report_mismatch("count", 32'(rsp_bus.count), 32'(want.count));
               if (rsp_bus.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_bus.is_empty), 32'(want.is_empty));
               checked++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = apply_request(req_bus.func, req_bus.position, req_bus.value);
            if (want.status == STATUS_RANGE) range_rejects++;
            if (want.status == STATUS_FULL) full_rejects++;
            if (want.found_at != 0) find_hits++;
            expected_q.push_back(want);
         end
      end
      pending_count <= expected_q.size();
      list_length   <= held;
   end

endmodule

### tb/sv/positional_list_engine_core_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_core_tb;
   import ple_pkg::*;

   localparam int unsigned DEPTH          = DEFAULT_DEPTH;
   localparam int          RANDOM_ITEMS   = 730;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          MAX_IDLE       = 14;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_type;

   logic clock;
   logic reset;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned list_length;
   int unsigned checked_count;
   int unsigned range_count;
   int unsigned full_count;
   int unsigned hit_count;

   int unsigned requests_sent;
   int          send_burst;
   int          recv_burst;
   int          idle_cycles;

   logic signed [DATA_W-1:0] value_pool [8] = '{
      32'sh0, 32'sh1, -32'sh1, 32'sh80000000, 32'sh7fffffff,
      32'sh5a5a5a5a, 32'sha5a5a5a5, 32'sd42
   };

   positional_list_engine_core #(.DEPTH(DEPTH)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   positional_list_engine_core_checker #(.DEPTH(DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .list_length   (list_length),
      .checked_count (checked_count),
      .range_count   (range_count),
      .full_count    (full_count),
      .hit_count     (hit_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // wait length per word, with occasional stretches of back-to-back traffic
   function automatic int draw_idle(ref int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(19) == 0) burst = $urandom_range(40, 10);
      return $urandom_range(MAX_IDLE);
   endfunction

   task automatic send_word(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                            input logic signed [DATA_W-1:0] v);
      int gap;
      gap = draw_idle(send_burst);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.func     <= f;
      req_bus.position <= p;
      req_bus.value    <= v;
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic send_random(input op_mix_type mix);
      int                       roll;
      int                       ins_pct;
      int                       del_pct;
      int                       rd_pct;
      int                       find_pct;
      int                       clr_pct;
      int unsigned              hi;
      logic [FUNC_W-1:0]        f;
      logic [POS_W-1:0]         p;
      logic signed [DATA_W-1:0] v;
      case (mix)
         MIX_FILL: begin
            ins_pct = 70; del_pct = 8; rd_pct = 8; find_pct = 10; clr_pct = 1;
         end
         MIX_DRAIN: begin
            ins_pct = 10; del_pct = 50; rd_pct = 15; find_pct = 15; clr_pct = 4;
         end
         default: begin
            ins_pct = 30; del_pct = 20; rd_pct = 20; find_pct = 20; clr_pct = 3;
         end
      endcase
      roll = $urandom_range(99);
      if (roll < ins_pct)
         f = FUNC_INSERT;
      else if (roll < ins_pct + del_pct)
         f = FUNC_DELETE;
      else if (roll < ins_pct + del_pct + rd_pct)
         f = FUNC_READ;
      else if (roll < ins_pct + del_pct + rd_pct + find_pct)
         f = FUNC_FIND;
      else if (roll < ins_pct + del_pct + rd_pct + find_pct + clr_pct)
         f = FUNC_CLEAR;
      else
         f = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      hi = (f == FUNC_INSERT) ? list_length + 1 : list_length;
      if ($urandom_range(99) < 85 && hi != 0)
         p = POS_W'($urandom_range(hi, 1));
      else
         p = POS_W'($urandom_range(31, 0));
      if ($urandom_range(99) < 50)
         v = value_pool[$urandom_range(7)];
      else
         v = $urandom;
      send_word(f, p, v);
   endtask

   // response side stalls independently of the request side
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_idle(recv_burst);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      op_mix_type mix;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.func     = FUNC_CLEAR;
      req_bus.position = '0;
      req_bus.value    = '0;
      requests_sent    = 0;
      send_burst       = 0;
      recv_burst       = 0;
      idle_cycles      = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: read and delete are out of range at every position, insert at 0 and 2
      send_word(FUNC_CLEAR, 5'd0, 32'sh0);
      send_word(FUNC_READ, 5'd1, 32'sh0);
      send_word(FUNC_DELETE, 5'd1, 32'sh0);
      send_word(FUNC_FIND, 5'd0, 32'sh0);
      send_word(FUNC_INSERT, 5'd0, 32'sh1);
      send_word(FUNC_INSERT, 5'd2, 32'sh1);
      // build front and back
      send_word(FUNC_INSERT, 5'd1, 32'sh80000000);
      send_word(FUNC_INSERT, 5'd2, 32'sh7fffffff);
      send_word(FUNC_INSERT, 5'd1, 32'sh0);
      send_word(FUNC_INSERT, 5'd4, -32'sh1);
      send_word(FUNC_FIND, 5'd0, 32'sh7fffffff);
      send_word(FUNC_FIND, 5'd31, 32'sd12345);
      send_word(FUNC_READ, 5'd1, 32'sh0);
      send_word(FUNC_READ, 5'd4, 32'sh0);
      send_word(FUNC_READ, 5'd5, 32'sh0);
      send_word(FUNC_READ, 5'd31, 32'shffffffff);
      send_word(FUNC_DELETE, 5'd2, 32'sh0);
      send_word(FUNC_DELETE, 5'd3, 32'sh0);
      send_word(FUNC_DELETE, 5'd1, 32'sh0);
      send_word(FUNC_SPARE_LO, 5'd31, 32'shffffffff);
      send_word(FUNC_SPARE_HI, 5'd1, 32'sh7fffffff);
      // duplicate value: find reports the first position
      send_word(FUNC_INSERT, 5'd2, 32'sh7fffffff);
      send_word(FUNC_FIND, 5'd0, 32'sh7fffffff);
      send_word(FUNC_CLEAR, 5'd31, 32'shffffffff);
      hold_until_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n / 60) % 4)
            0: mix = MIX_FILL;
            2: mix = MIX_DRAIN;
            default: mix = MIX_BALANCED;
         endcase
         if (n % 150 == 149) hold_until_drained();
         send_random(mix);
      end

      hold_until_drained();
      repeat (8) @(posedge clock);

      $display("run covered %0d requests and %0d checked responses", requests_sent,
               checked_count);
      $display("range rejects %0d, full-list rejects %0d, find hits %0d", range_count,
               full_count, hit_count);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
